/* sv/hwcv_pkg.sv */
// Shared types, codes and constants of the HSV window color vote block.
package hwcv_pkg;

  localparam int unsigned BOUNDS_BITS    = 48;
  localparam int unsigned CHAN_BITS      = 8;
  localparam int unsigned MIN_COUNT_BITS = 22;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = BOUNDS_BITS;

  localparam int unsigned DEF_COORD_BITS = 11;
  localparam int unsigned DEF_COUNT_BITS = 22;

  // Top of the wrapped interval, applied to all three channels.
  localparam logic [CHAN_BITS-1:0] WRAP_TOP = CHAN_BITS'(180);

  // Opcodes of the input channel.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_ONE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_TWO  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_X      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_Y      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_COUNT  = 3'd6;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_ONE  = 2'd1,
    VERDICT_TWO  = 2'd2
  } verdict_e;

  // Per-item update request from the sample stage to the counters.
  typedef struct packed {
    logic clear;
    logic hit_one;
    logic hit_two;
  } match_t;

endpackage

/* sv/hwcv_if.sv */
// Valid/ready stream interfaces for the pixel input and the vote result channels.
interface hwcv_in_if #(
  parameter int unsigned COORD_BITS = hwcv_pkg::DEF_COORD_BITS
);
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [hwcv_pkg::CHAN_BITS-1:0] hue;
  logic [hwcv_pkg::CHAN_BITS-1:0] saturation;
  logic [hwcv_pkg::CHAN_BITS-1:0] brightness;
  logic [COORD_BITS-1:0]          column;
  logic [COORD_BITS-1:0]          row;

  modport source (output valid, opcode, hue, saturation, brightness, column, row,
                  input ready);
  modport sink   (input valid, opcode, hue, saturation, brightness, column, row,
                  output ready);
endinterface

interface hwcv_out_if #(
  parameter int unsigned COUNT_BITS = hwcv_pkg::DEF_COUNT_BITS
);
  logic                      valid;
  logic                      ready;
  hwcv_pkg::verdict_e        verdict;
  logic [COUNT_BITS-1:0]     count_one;
  logic [COUNT_BITS-1:0]     count_two;

  modport source (output valid, verdict, count_one, count_two, input ready);
  modport sink   (input valid, verdict, count_one, count_two, output ready);
endinterface

/* sv/hwcv_color_match.sv */
// Three-channel HSV bound test against one packed color bound set.
module hwcv_color_match (
  input  logic [hwcv_pkg::BOUNDS_BITS-1:0] bounds_i,
  input  logic [hwcv_pkg::CHAN_BITS-1:0]   hue_i,
  input  logic [hwcv_pkg::CHAN_BITS-1:0]   sat_i,
  input  logic [hwcv_pkg::CHAN_BITS-1:0]   val_i,
  output logic                             match_o
);
  import hwcv_pkg::*;

  function automatic logic in_range(input logic [CHAN_BITS-1:0] n,
                                    input logic [CHAN_BITS-1:0] lo,
                                    input logic [CHAN_BITS-1:0] hi);
    logic res;
    if (lo < hi) begin
      res = (lo <= n) && (n <= hi);
    end else begin
      // bounds equal or crossed over: take the upper band and the lower band
      res = ((lo <= n) && (n <= WRAP_TOP)) || (n <= hi);
    end
    return res;
  endfunction

  logic hue_ok, sat_ok, val_ok;

  assign hue_ok  = in_range(hue_i, bounds_i[7:0],   bounds_i[15:8]);
  assign sat_ok  = in_range(sat_i, bounds_i[23:16], bounds_i[31:24]);
  assign val_ok  = in_range(val_i, bounds_i[39:32], bounds_i[47:40]);
  assign match_o = hue_ok && sat_ok && val_ok;

endmodule

/* sv/hwcv_vote_counter.sv */
// Saturating match counters and the vote verdict register.
module hwcv_vote_counter #(
  parameter int unsigned COUNT_BITS = hwcv_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                advance_i,
  input  hwcv_pkg::match_t                    match_i,
  input  logic [hwcv_pkg::MIN_COUNT_BITS-1:0] min_count_i,
  output logic [COUNT_BITS-1:0]               count_one_o,
  output logic [COUNT_BITS-1:0]               count_two_o,
  output hwcv_pkg::verdict_e                  verdict_o
);
  import hwcv_pkg::*;

  localparam int unsigned CmpBits =
    (COUNT_BITS > MIN_COUNT_BITS) ? COUNT_BITS : MIN_COUNT_BITS;

  logic [COUNT_BITS-1:0] cnt_one_d, cnt_one_q;
  logic [COUNT_BITS-1:0] cnt_two_d, cnt_two_q;
  verdict_e              verdict_d, verdict_q;
  logic [CmpBits-1:0]    one_ext, two_ext, min_ext;

  always_comb begin
    if (match_i.clear) begin
      cnt_one_d = '0;
      cnt_two_d = '0;
    end else begin
      cnt_one_d = cnt_one_q;
      cnt_two_d = cnt_two_q;
      // hold at the top instead of wrapping
      if (match_i.hit_one && (cnt_one_q != '1)) begin
        cnt_one_d = cnt_one_q + COUNT_BITS'(1);
      end
      if (match_i.hit_two && (cnt_two_q != '1)) begin
        cnt_two_d = cnt_two_q + COUNT_BITS'(1);
      end
    end
  end

  assign one_ext = CmpBits'(cnt_one_d);
  assign two_ext = CmpBits'(cnt_two_d);
  assign min_ext = CmpBits'(min_count_i);

  always_comb begin
    if ((one_ext > two_ext) && (one_ext >= min_ext)) begin
      verdict_d = VERDICT_ONE;
    end else if ((two_ext > one_ext) && (two_ext >= min_ext)) begin
      verdict_d = VERDICT_TWO;
    end else begin
      verdict_d = VERDICT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_one_q <= '0;
      cnt_two_q <= '0;
      verdict_q <= VERDICT_NONE;
    end else if (advance_i) begin
      cnt_one_q <= cnt_one_d;
      cnt_two_q <= cnt_two_d;
      verdict_q <= verdict_d;
    end
  end

  assign count_one_o = cnt_one_q;
  assign count_two_o = cnt_two_q;
  assign verdict_o   = verdict_q;

endmodule

/* sv/hsv_window_color_vote.sv */
// HSV window color vote: counts pixels of two colors in a window and reports a vote.
//
// Pixels enter on in_i (valid/ready) with hue, saturation, brightness and their
// column/row. A pixel inside the configured window is tested against both color
// bound sets; each match bumps its own saturating counter. opcode OP_CLEAR zeroes
// both counters. Every input transfer yields exactly one result on out_o: the
// verdict (none, color one, color two) and both counts after that item.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write it only while the block is idle, as the block itself does not enforce
// this. Indexes beyond the register list are ignored. Between an input transfer
// and its result lie one input register, then the match and counter logic feeding
// the result register. One item is taken every cycle while out_o is not stalled;
// the rate is set by the counter update loop.
// Reset clears the configuration registers, both counters and both pipeline valid
// flags. When out_o stalls, the result holds and the input register, if empty, still
// takes one more item, after which in_i.ready drops until the result is taken.
module hsv_window_color_vote #(
  parameter int unsigned COORD_BITS = hwcv_pkg::DEF_COORD_BITS,
  parameter int unsigned COUNT_BITS = hwcv_pkg::DEF_COUNT_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  hwcv_in_if.sink                            in_i,
  hwcv_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [hwcv_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [hwcv_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import hwcv_pkg::*;

  // configuration registers
  logic [BOUNDS_BITS-1:0]    bounds_one_q, bounds_two_q;
  logic [COORD_BITS-1:0]     win_x_q, win_y_q, win_w_q, win_h_q;
  logic [MIN_COUNT_BITS-1:0] min_count_q;

  // input stage
  logic                  s1_valid_q;
  logic                  s1_op_q;
  logic [CHAN_BITS-1:0]  s1_hue_q, s1_sat_q, s1_val_q;
  logic [COORD_BITS-1:0] s1_col_q, s1_row_q;

  logic out_valid_q;
  logic advance;
  logic in_fire;

  logic [COORD_BITS:0] x_end, y_end;
  logic                in_window;
  logic                match_one, match_two;
  match_t              upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_one_q <= '0;
      bounds_two_q <= '0;
      win_x_q      <= '0;
      win_y_q      <= '0;
      win_w_q      <= '0;
      win_h_q      <= '0;
      min_count_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLOR_ONE:  bounds_one_q <= cfg_data_i[BOUNDS_BITS-1:0];
        CFG_COLOR_TWO:  bounds_two_q <= cfg_data_i[BOUNDS_BITS-1:0];
        CFG_WIN_X:      win_x_q      <= cfg_data_i[COORD_BITS-1:0];
        CFG_WIN_Y:      win_y_q      <= cfg_data_i[COORD_BITS-1:0];
        CFG_WIN_WIDTH:  win_w_q      <= cfg_data_i[COORD_BITS-1:0];
        CFG_WIN_HEIGHT: win_h_q      <= cfg_data_i[COORD_BITS-1:0];
        CFG_MIN_COUNT:  min_count_q  <= cfg_data_i[MIN_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // advance the whole pipe when the result slot is free or being taken
  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= in_i.opcode;
      s1_hue_q <= in_i.hue;
      s1_sat_q <= in_i.saturation;
      s1_val_q <= in_i.brightness;
      s1_col_q <= in_i.column;
      s1_row_q <= in_i.row;
    end
  end

  // window end computed one bit wider so it never wraps
  assign x_end     = {1'b0, win_x_q} + {1'b0, win_w_q};
  assign y_end     = {1'b0, win_y_q} + {1'b0, win_h_q};
  assign in_window = (s1_col_q >= win_x_q) && ({1'b0, s1_col_q} < x_end) &&
                     (s1_row_q >= win_y_q) && ({1'b0, s1_row_q} < y_end);

  hwcv_color_match u_match_one (
    .bounds_i (bounds_one_q),
    .hue_i    (s1_hue_q),
    .sat_i    (s1_sat_q),
    .val_i    (s1_val_q),
    .match_o  (match_one)
  );

  hwcv_color_match u_match_two (
    .bounds_i (bounds_two_q),
    .hue_i    (s1_hue_q),
    .sat_i    (s1_sat_q),
    .val_i    (s1_val_q),
    .match_o  (match_two)
  );

  assign upd.clear   = (s1_op_q == OP_CLEAR);
  assign upd.hit_one = (s1_op_q == OP_SAMPLE) && in_window && match_one;
  assign upd.hit_two = (s1_op_q == OP_SAMPLE) && in_window && match_two;

  hwcv_vote_counter #(
    .COUNT_BITS (COUNT_BITS)
  ) u_counter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance && s1_valid_q),
    .match_i     (upd),
    .min_count_i (min_count_q),
    .count_one_o (out_o.count_one),
    .count_two_o (out_o.count_two),
    .verdict_o   (out_o.verdict)
  );

  assign out_o.valid = out_valid_q;

  // clear item reaching the result register leaves both counts at zero
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_valid_q && (s1_op_q == OP_CLEAR)) |=>
      ((out_o.count_one == '0) && (out_o.count_two == '0)))
    else $error("counters not cleared by clear item");

  // sample items never lower a count
  a_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_valid_q && (s1_op_q == OP_SAMPLE)) |=>
      ((out_o.count_one >= $past(out_o.count_one)) &&
       (out_o.count_two >= $past(out_o.count_two))))
    else $error("count decreased on a sample item");

  // verdict agrees with the counts it is shown with
  a_verdict_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      (((out_o.verdict == VERDICT_ONE) && (out_o.count_one > out_o.count_two)) ||
       ((out_o.verdict == VERDICT_TWO) && (out_o.count_two > out_o.count_one)) ||
       (out_o.verdict == VERDICT_NONE)))
    else $error("verdict contradicts counts");

  // counts only move when a stage-one item transfers into the result slot
  a_counts_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && s1_valid_q) |=>
      ($stable(out_o.count_one) && $stable(out_o.count_two)))
    else $error("counts changed without an item");

endmodule
